// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the locality-improved kernel.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define LIK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lik assertion failed");

// Checked on every rising clock edge, reset included.
`define LIK_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("lik reset assertion failed");

`endif

// ----- design/lik_pkg.sv -----
// ----------------------------------------------------------------------------
// Locality-improved kernel package
// Widths, register indexes and the command and status bundles shared by
// the controller and the datapath.
// ----------------------------------------------------------------------------
package lik_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned InDataW  = 2 * CharW;
  localparam int unsigned ValueW   = 64;
  localparam int unsigned DigitW   = 16;
  localparam int unsigned NumDigit = ValueW / DigitW;
  localparam int unsigned DigIdxW  = $clog2(NumDigit);
  localparam int unsigned ExpW     = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_WINDOW     = 2'd0,
    CFG_WINDOW_EXPONENT = 2'd1,
    CFG_TOTAL_EXPONENT  = 2'd2
  } lik_cfg_e;

  typedef struct packed {
    logic load;       // shift in the match bit of the accepted pair
    logic pow_start;  // load the power engine
    logic pow_total;  // power the running sum with d2 instead of the count with d1
    logic acc;        // add the finished window power to the sum
    logic emit;       // move the total power to the output and clear the state
  } lik_cmd_t;

  typedef struct packed {
    logic window_full;
    logic last;
    logic pow_done;
    logic out_free;
  } lik_sts_t;

endpackage

// ----- design/lik_dp.sv -----
// ----------------------------------------------------------------------------
// Locality-improved kernel datapath
// Match history, window count, saturating power engine built on one shared
// 64x16 multiplier, saturating accumulator, configuration and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lik_dp
  import lik_pkg::*;
#(
  parameter int unsigned MaxHalfWindow = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                in_last_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [ValueW-1:0]   out_data_o,
  output logic                out_sat_o,
  input  lik_cmd_t            cmd_i,
  output lik_sts_t            sts_o
);

  localparam int unsigned HistBits = 2 * MaxHalfWindow + 1;
  localparam int unsigned FillW    = $clog2(HistBits + 1);

  logic [CfgDataW-1:0] cfg_hw_q, cfg_d1_q, cfg_d2_q;

  logic [HistBits-1:0] hist_q, hist_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic [ValueW-1:0]   sum_q, sum_d;
  logic                ovf_q, ovf_d;
  logic                last_q;

  logic [ExpW-1:0]     pw_exp_q, pw_exp_d;
  logic [ValueW-1:0]   pw_r_q, pw_r_d;
  logic [ValueW-1:0]   pw_base_q, pw_base_d;
  logic                pw_ovf_q, pw_ovf_d;
  logic [ValueW-1:0]   mul_acc_q, mul_acc_d;
  logic                mul_ovf_q, mul_ovf_d;
  logic [DigIdxW-1:0]  dig_q, dig_d;
  logic [DigIdxW-1:0]  top_q, top_d;

  logic                out_valid_q;
  logic [ValueW-1:0]   out_data_q;
  logic                out_sat_q;

  logic [FillW-1:0]    half_l;
  logic [FillW-1:0]    win_width;
  logic [FillW-1:0]    count;
  logic                window_full;
  logic [DigitW-1:0]   digit;
  logic [ValueW+DigitW-1:0] prod;
  logic [ValueW+DigitW:0]   mul_sum;
  logic                step_ovf;
  logic [ValueW:0]     add_sum;
  logic [ValueW-1:0]   start_base;
  logic [DigIdxW-1:0]  start_top;
  logic                match;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_hw_q <= CfgDataW'(1);
      cfg_d1_q <= CfgDataW'(1);
      cfg_d2_q <= CfgDataW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HALF_WINDOW:     cfg_hw_q <= cfg_data_i;
        CFG_WINDOW_EXPONENT: cfg_d1_q <= cfg_data_i;
        CFG_TOTAL_EXPONENT:  cfg_d2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Window width and the number of matches inside it.
  always_comb begin
    if (int'(cfg_hw_q) > int'(MaxHalfWindow)) begin
      half_l = FillW'(MaxHalfWindow);
    end else begin
      half_l = FillW'(cfg_hw_q);
    end
    win_width   = FillW'(2 * int'(half_l) + 1);
    window_full = (fill_q >= win_width);
  end

  always_comb begin
    count = '0;
    for (int k = 0; k < int'(HistBits); k++) begin
      if (k < int'(win_width)) begin
        count = count + FillW'(hist_q[k]);
      end
    end
  end

  assign match = (in_data_i[CharW-1:0] == in_data_i[InDataW-1:CharW]);

  // Power engine: each multiply walks the base one 16-bit digit a cycle,
  // most significant digit first, so a product that passes 64 bits is caught.
  assign digit    = pw_base_q[dig_q*DigitW +: DigitW];
  assign prod     = (ValueW+DigitW)'(pw_r_q) * (ValueW+DigitW)'(digit);
  assign mul_sum  = {1'b0, mul_acc_q, {DigitW{1'b0}}} + {1'b0, prod};
  assign step_ovf = mul_ovf_q | (|mul_sum[ValueW+DigitW:ValueW]);

  assign start_base = cmd_i.pow_total ? sum_q : ValueW'(count);

  always_comb begin
    start_top = '0;
    for (int k = 0; k < int'(NumDigit); k++) begin
      if (start_base[k*DigitW +: DigitW] != '0) begin
        start_top = DigIdxW'(k);
      end
    end
  end

  always_comb begin
    pw_exp_d  = pw_exp_q;
    pw_r_d    = pw_r_q;
    pw_base_d = pw_base_q;
    pw_ovf_d  = pw_ovf_q;
    mul_acc_d = mul_acc_q;
    mul_ovf_d = mul_ovf_q;
    dig_d     = dig_q;
    top_d     = top_q;
    if (cmd_i.pow_start) begin
      pw_exp_d  = cmd_i.pow_total ? cfg_d2_q : cfg_d1_q;
      pw_r_d    = ValueW'(1);
      pw_base_d = start_base;
      pw_ovf_d  = 1'b0;
      mul_acc_d = '0;
      mul_ovf_d = 1'b0;
      dig_d     = start_top;
      top_d     = start_top;
    end else if (pw_exp_q != '0) begin
      if (dig_q == '0) begin
        pw_r_d    = step_ovf ? '1 : mul_sum[ValueW-1:0];
        pw_ovf_d  = pw_ovf_q | step_ovf;
        pw_exp_d  = pw_exp_q - ExpW'(1);
        mul_acc_d = '0;
        mul_ovf_d = 1'b0;
        dig_d     = top_q;
      end else begin
        mul_acc_d = mul_sum[ValueW-1:0];
        mul_ovf_d = step_ovf;
        dig_d     = dig_q - DigIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_exp_q <= '0;
    end else begin
      pw_exp_q <= pw_exp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pw_r_q    <= pw_r_d;
    pw_base_q <= pw_base_d;
    pw_ovf_q  <= pw_ovf_d;
    mul_acc_q <= mul_acc_d;
    mul_ovf_q <= mul_ovf_d;
    dig_q     <= dig_d;
    top_q     <= top_d;
  end

  // Kernel state: history, fill level, saturating sum and overflow mark.
  assign add_sum = {1'b0, sum_q} + {1'b0, pw_r_q};

  always_comb begin
    hist_d = hist_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    ovf_d  = ovf_q;
    if (cmd_i.load) begin
      hist_d = {hist_q[HistBits-2:0], match};
      if (fill_q < FillW'(HistBits)) begin
        fill_d = fill_q + FillW'(1);
      end
    end
    if (cmd_i.acc) begin
      sum_d = add_sum[ValueW] ? '1 : add_sum[ValueW-1:0];
      ovf_d = ovf_q | pw_ovf_q | add_sum[ValueW];
    end
    if (cmd_i.emit) begin
      hist_d = '0;
      fill_d = '0;
      sum_d  = '0;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      hist_q <= hist_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      last_q <= in_last_i;
    end
  end

  // Output register; a new result is only loaded when the slot is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= pw_r_q;
      out_sat_q  <= ovf_q | pw_ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_sat_o   = out_sat_q;

  always_comb begin
    sts_o.window_full = window_full;
    sts_o.last        = last_q;
    sts_o.pow_done    = (pw_exp_q == '0);
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  `LIK_ASSERT(a_fill_bound, fill_q <= FillW'(HistBits))
  `LIK_ASSERT(a_emit_clears,
      cmd_i.emit |=> (sum_q == '0) && (fill_q == '0) && !ovf_q && out_valid_q)
  `LIK_ASSERT(a_exp_counts_down,
      (pw_exp_q != '0) && (dig_q == '0) && !cmd_i.pow_start
      |=> pw_exp_q == $past(pw_exp_q) - ExpW'(1))

endmodule

// ----- design/lik_ctrl.sv -----
// ----------------------------------------------------------------------------
// Locality-improved kernel controller
// Sequences one pair at a time: shift in, window power, accumulate, and on
// the last pair the total power and the hand-off to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lik_ctrl
  import lik_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output lik_cmd_t cmd_o,
  input  lik_sts_t sts_i
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CHK  = 5'b00010,
    ST_POWW = 5'b00100,
    ST_LST  = 5'b01000,
    ST_POWT = 5'b10000
  } lik_state_e;

  lik_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts_i.window_full) begin
          cmd_o.pow_start = 1'b1;
          state_d         = ST_POWW;
        end else begin
          state_d = ST_LST;
        end
      end
      ST_POWW: begin
        if (sts_i.pow_done) begin
          cmd_o.acc = 1'b1;
          state_d   = ST_LST;
        end
      end
      ST_LST: begin
        if (sts_i.last) begin
          cmd_o.pow_start = 1'b1;
          cmd_o.pow_total = 1'b1;
          state_d         = ST_POWT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_POWT: begin
        // Hold the finished total until the output slot drains.
        if (sts_i.pow_done && sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `LIK_ASSERT(a_load_to_chk, in_valid_i && in_ready_o |=> state_q == ST_CHK)
  `LIK_ASSERT(a_emit_when_ready, cmd_o.emit |-> sts_i.pow_done && sts_i.out_free)
  `LIK_ASSERT(a_one_cmd, $onehot0({cmd_o.load, cmd_o.pow_start, cmd_o.acc, cmd_o.emit}))
  `LIK_ASSERT_RST(a_reset_idle, !rst_ni |=> state_q == ST_IDLE)

endmodule

// ----- design/locality_improved_kernel.sv -----
// ----------------------------------------------------------------------------
// Locality-improved string kernel
// Input stream: one aligned character pair per request, tlast on the final
// position of the string pair. Each position from 2L onward closes a window
// of 2L+1 match bits whose count is raised to d1 and added to a saturating
// 64-bit sum. After the last pair the sum raised to d2 leaves on the output
// stream, with tuser set if any product or sum was clamped; the state clears.
// Pairs are handled one at a time: the next pair is taken only once the
// previous one is shifted in and, if it closes a window, powered and
// accumulated. The last pair adds the total power: d2 multiplies, each
// walking the 16-bit digits of the sum down from its highest nonzero
// digit; the result then goes to the output register. One 64x16
// multiplier is shared by both powers.
// The result waits in an output register, so new pairs are taken while the
// receiver stalls; only the next result waits for that register to drain.
// Reset restores L = d1 = d2 = 1 and clears the history and the sum.
// Configuration writes are always ready and must arrive while idle.
// ----------------------------------------------------------------------------
module locality_improved_kernel
  import lik_pkg::*;
#(
  parameter int unsigned MAX_HALF_WINDOW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // char_a [7:0], char_b [15:8]
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [ValueW-1:0]   m_axis_tdata,   // kernel_value [63:0]
  output logic                m_axis_tuser,   // saturated [0]
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  lik_cmd_t cmd;
  lik_sts_t sts;

  assign cfg_ready_o = 1'b1;

  lik_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lik_dp #(
    .MaxHalfWindow (MAX_HALF_WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_sat_o   (m_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- tb/sv/tb_locality_improved_kernel.sv -----
// ----------------------------------------------------------------------------
// Locality-improved kernel testbench
// Streams aligned character pairs into the kernel. A queue-fed driver offers
// them, a clocked predictor scores every accepted pair, and a monitor compares
// each kernel result with the oldest prediction. Settings change between
// phases while the block is idle, and the two stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_locality_improved_kernel;
  import lik_pkg::*;

  localparam int unsigned MaxHalf      = 8;
  localparam int unsigned HistW        = 2 * MaxHalf + 1;
  localparam int unsigned SettleCycles = 100;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned NumPhases    = 14;
  localparam int unsigned PhaseItems   = 100;
  localparam int unsigned RxHoldPhase  = 5;
  localparam int unsigned DrainPhase   = 9;
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 2'd3;

  typedef struct packed {
    logic [CharW-1:0] a;
    logic [CharW-1:0] b;
    logic             last;
  } pair_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              sat;
  } kernel_res_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // char_a [7:0], char_b [15:8]
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [ValueW-1:0]   m_axis_tdata;         // kernel_value [63:0]
  logic                m_axis_tuser;         // saturated [0]
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // Predictor copy of the registers and the string state.
  logic [ExpW-1:0]   half_reg;
  logic [ExpW-1:0]   win_exp_reg;
  logic [ExpW-1:0]   tot_exp_reg;
  logic [HistW-1:0]  match_bits;
  logic [4:0]        seen_count;
  logic [ValueW-1:0] power_sum;
  logic              clamped;

  pair_t       pair_q[$];
  kernel_res_t kernel_exp_q[$];
  pair_t       offered;

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          drain_mode   = 1'b0;
  bit          long_hold_en = 1'b0;
  int unsigned hold_count   = 0;
  int unsigned pairs_queued = 0;
  int unsigned pairs_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned sat_seen     = 0;
  int unsigned err_count    = 0;

  locality_improved_kernel #(
    .MAX_HALF_WINDOW(MaxHalf)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [ValueW-1:0] mul_clamp(input logic [ValueW-1:0] x,
                                                  input logic [ValueW-1:0] y,
                                                  inout logic ovf);
    logic [2*ValueW-1:0] wide;
    wide = x * y;
    if (wide[2*ValueW-1:ValueW] != '0) begin
      ovf = 1'b1;
      return '1;
    end
    return wide[ValueW-1:0];
  endfunction

  function automatic logic [ValueW-1:0] pow_clamp(input logic [ValueW-1:0] base,
                                                  input logic [ExpW-1:0] power,
                                                  inout logic ovf);
    logic [ValueW-1:0] r;
    r = ValueW'(1);
    for (int unsigned k = 0; k < power; k++) r = mul_clamp(r, base, ovf);
    return r;
  endfunction

  function automatic int unsigned eff_half();
    return (half_reg > MaxHalf) ? MaxHalf : half_reg;
  endfunction

  task automatic clear_string();
    match_bits = '0;
    seen_count = '0;
    power_sum  = '0;
    clamped    = 1'b0;
  endtask

  // Scores one accepted pair and, on the last one, queues the kernel value.
  task automatic absorb_pair(input pair_t pr);
    int unsigned       span;
    logic [ValueW-1:0] ones;
    logic [ValueW-1:0] p;
    logic              ovf;
    kernel_res_t       res;
    span = 2 * eff_half() + 1;
    match_bits = {match_bits[HistW-2:0], pr.a == pr.b};
    if (seen_count < HistW) seen_count++;
    if (seen_count >= span) begin
      ones = '0;
      for (int unsigned k = 0; k < span; k++) ones += ValueW'(match_bits[k]);
      p = pow_clamp(ones, win_exp_reg, clamped);
      if (power_sum > ~p) begin
        power_sum = '1;
        clamped   = 1'b1;
      end else begin
        power_sum += p;
      end
    end
    if (pr.last) begin
      ovf       = clamped;
      res.value = pow_clamp(power_sum, tot_exp_reg, ovf);
      res.sat   = ovf;
      kernel_exp_q.push_back(res);
      clear_string();
    end
  endtask

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Driver: offers queued pairs and holds each request until it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_pair(offered);
        pairs_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pair_q.size() != 0 && !(drain_mode && kernel_exp_q.size() != 0) &&
            $urandom_range(99) >= tx_idle_pct) begin
          offered = pair_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {offered.b, offered.a};
          s_axis_tlast  <= offered.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results and drives the receiver's ready.
  always @(posedge clk_i) begin
    kernel_res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (m_axis_tuser) sat_seen++;
        if (kernel_exp_q.size() == 0) begin
          flag_error($sformatf("unexpected result value=%h sat=%b", m_axis_tdata,
                               m_axis_tuser));
        end else begin
          want = kernel_exp_q.pop_front();
          if (m_axis_tdata !== want.value || m_axis_tuser !== want.sat)
            flag_error($sformatf("expected value=%h sat=%b, got value=%h sat=%b",
                                 want.value, want.sat, m_axis_tdata, m_axis_tuser));
        end
      end
      // One long hold lets the output register fill and stall the input side.
      if (long_hold_en && hold_count < LongHold) begin
        hold_count++;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_HALF_WINDOW:     half_reg    = val;
      CFG_WINDOW_EXPONENT: win_exp_reg = val;
      CFG_TOTAL_EXPONENT:  tot_exp_reg = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [CfgDataW-1:0] l, input logic [CfgDataW-1:0] d1,
                           input logic [CfgDataW-1:0] d2);
    write_reg(CFG_HALF_WINDOW, l);
    write_reg(CFG_WINDOW_EXPONENT, d1);
    write_reg(CFG_TOTAL_EXPONENT, d2);
  endtask

  task automatic push_pair(input logic [CharW-1:0] a, input logic [CharW-1:0] b,
                           input logic last);
    pair_t pr;
    pr.a    = a;
    pr.b    = b;
    pr.last = last;
    pair_q.push_back(pr);
    pairs_queued++;
  endtask

  task automatic queue_string(input int unsigned len, input int unsigned match_pct,
                              input bit close);
    logic [CharW-1:0] a;
    logic [CharW-1:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      a = CharW'($urandom);
      b = ($urandom_range(99) < match_pct) ? a : CharW'($urandom);
      push_pair(a, b, close && (i == len - 1));
    end
  endtask

  // Waits until every queued pair is taken and every result is out, then
  // gives the block time to finish a pair that produces no result.
  task automatic wait_idle();
    while (pairs_taken != pairs_queued || kernel_exp_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned queued;
    int unsigned len;
    int unsigned match_pct;
    int unsigned span;
    half_reg    = ExpW'(1);
    win_exp_reg = ExpW'(1);
    tot_exp_reg = ExpW'(1);
    clear_string();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: a one-pair string, an all-match window, an all-miss one.
    push_pair(8'h00, 8'h00, 1'b1);
    push_pair(8'hFF, 8'hFF, 1'b0);
    push_pair(8'h00, 8'h00, 1'b0);
    push_pair(8'h5A, 8'h5A, 1'b1);
    push_pair(8'h00, 8'hFF, 1'b0);
    push_pair(8'hFF, 8'h00, 1'b0);
    push_pair(8'hAA, 8'h55, 1'b1);
    wait_idle();

    // Zero powers, so a zero count still contributes one.
    write_all(4'd0, 4'd0, 4'd0);
    push_pair(8'h01, 8'h02, 1'b1);
    wait_idle();

    // Oversized half width is clamped; the total power of the full window's sum overflows.
    write_all(4'd15, 4'd15, 4'd15);
    write_reg(CfgUnusedIdx, 4'd5);
    queue_string(HistW, 100, 1'b1);

    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      wait_idle();
      case (phase)
        0:       write_all(4'd0, 4'd0, 4'd0);
        1:       write_all(4'd15, 4'd15, 4'd15);
        2:       write_all(4'd8, 4'd8, 4'd8);
        default: write_all(CfgDataW'($urandom_range(15)), CfgDataW'($urandom_range(15)),
                           CfgDataW'($urandom_range(15)));
      endcase
      if (phase % 5 == 4) write_reg(CfgUnusedIdx, CfgDataW'($urandom_range(15)));
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 84; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 84; end
        default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
      endcase
      drain_mode = (phase == DrainPhase);
      if (phase == RxHoldPhase) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        long_hold_en = 1'b1;
      end
      span   = 2 * eff_half() + 1;
      queued = 0;
      while (queued < PhaseItems) begin
        if (phase == RxHoldPhase) len = $urandom_range(1, 3);
        else if ($urandom_range(9) == 0) len = $urandom_range(1, 40);
        else len = $urandom_range(1, span + 8);
        case ($urandom_range(3))
          0:       match_pct = 100;
          1:       match_pct = 0;
          default: match_pct = $urandom_range(100);
        endcase
        queue_string(len, match_pct, 1'b1);
        queued += len;
      end
      // An open string carries over, so the next settings apply mid-string.
      if (phase != NumPhases - 1 && $urandom_range(2) == 0)
        queue_string($urandom_range(1, 8), 60, 1'b0);
    end

    wait_idle();
    $display("Run covered %0d character pairs over %0d setting phases.", pairs_taken,
             NumPhases);
    $display("Checked %0d kernel results, %0d of them saturated.", results_seen, sat_seen);
    if (err_count == 0 && kernel_exp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
